// ===== rtl/aging_priority_scheduler_top_macros.svh =====
// Assertion macros shared by the scheduler modules.
`ifndef AGING_PRIORITY_SCHEDULER_TOP_MACROS_SVH
`define AGING_PRIORITY_SCHEDULER_TOP_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define APS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define APS_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define APS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/aps_pkg.sv =====
// Package with the types, constants and codes of the aging priority scheduler.
package aps_pkg;

  localparam int TASK_SLOTS = 16;
  localparam int SLOT_W     = $clog2(TASK_SLOTS);
  localparam int CNT_W      = $clog2(TASK_SLOTS + 1);
  localparam int PRIO_W     = 16;
  localparam int AGE_W      = 16;

  localparam int PRIO_ACCEPT_LOW  = -20;
  localparam int PRIO_ACCEPT_HIGH = 20;
  localparam int PRIO_MAX         = 32767;
  localparam int PRIO_MIN         = -32768;

  localparam logic [1:0] OP_SET    = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_SCHED  = 2'd3;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_EMPTY  = 2'd1;
  localparam logic [1:0] STAT_REJECT = 2'd2;
  localparam logic [1:0] STAT_LISTED = 2'd3;

  typedef enum logic [1:0] {
    ALU_CMP,
    ALU_AGE,
    ALU_RESTORE
  } alu_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_FIND,
    S_SHIFT,
    S_SELECT,
    S_AGE,
    S_RESTORE
  } state_t;

  typedef struct packed {
    logic                     prio_we;
    logic                     age_we;
    logic [SLOT_W-1:0]        task_waddr;
    logic signed [PRIO_W-1:0] prio_wdata;
    logic [AGE_W-1:0]         age_wdata;
    logic                     list_we;
    logic [SLOT_W-1:0]        list_waddr;
    logic [SLOT_W-1:0]        list_wdata;
    logic                     flag_we;
    logic [SLOT_W-1:0]        flag_waddr;
    logic                     flag_wdata;
    logic                     count_we;
    logic [CNT_W-1:0]         count_wdata;
  } store_wr_t;

endpackage

// ===== rtl/aps_alu.sv =====
// Shared saturating arithmetic unit: priority compare, aging step and restore.
module aps_alu (
  input  aps_pkg::alu_op_t                    op,
  input  logic signed [aps_pkg::PRIO_W-1:0]   a,
  input  logic signed [aps_pkg::PRIO_W-1:0]   b,
  input  logic [aps_pkg::AGE_W-1:0]           age,
  output logic                                lt,
  output logic signed [aps_pkg::PRIO_W-1:0]   prio_res,
  output logic [aps_pkg::AGE_W-1:0]           age_res
);

  logic signed [aps_pkg::PRIO_W+1:0] opa;
  logic signed [aps_pkg::PRIO_W+1:0] opb;
  logic signed [aps_pkg::PRIO_W+1:0] sum;

  always_comb begin
    opa = {{2{a[aps_pkg::PRIO_W-1]}}, a};
    case (op)
      aps_pkg::ALU_CMP:     opb = -$signed({{2{b[aps_pkg::PRIO_W-1]}}, b});
      aps_pkg::ALU_AGE:     opb = -(aps_pkg::PRIO_W+2)'(1);
      aps_pkg::ALU_RESTORE: opb = $signed({2'b00, age});
      default:              opb = '0;
    endcase
    sum = opa + opb;
    lt  = sum[aps_pkg::PRIO_W+1];

    if (sum > aps_pkg::PRIO_MAX) begin
      prio_res = aps_pkg::PRIO_W'(aps_pkg::PRIO_MAX);
    end else if (sum < aps_pkg::PRIO_MIN) begin
      prio_res = aps_pkg::PRIO_W'(aps_pkg::PRIO_MIN);
    end else begin
      prio_res = sum[aps_pkg::PRIO_W-1:0];
    end

    // The aging count only grows in the aging step; a restore clears it.
    if (op == aps_pkg::ALU_AGE) begin
      age_res = (age == '1) ? age : age + aps_pkg::AGE_W'(1);
    end else begin
      age_res = '0;
    end
  end

endmodule

// ===== rtl/aps_store.sv =====
// Task table, ready list, listed flags and list count of the scheduler.
`include "aging_priority_scheduler_top_macros.svh"

module aps_store (
  input  logic                                clk,
  input  logic                                rst,
  input  aps_pkg::store_wr_t                  wr,
  input  logic [aps_pkg::SLOT_W-1:0]          task_raddr,
  input  logic [aps_pkg::SLOT_W-1:0]          list_raddr,
  input  logic [aps_pkg::SLOT_W-1:0]          flag_raddr,
  output logic signed [aps_pkg::PRIO_W-1:0]   prio_rd,
  output logic [aps_pkg::AGE_W-1:0]           age_rd,
  output logic [aps_pkg::SLOT_W-1:0]          list_rd,
  output logic                                flag_rd,
  output logic [aps_pkg::CNT_W-1:0]           count
);

  logic signed [aps_pkg::PRIO_W-1:0] prio_mem [aps_pkg::TASK_SLOTS];
  logic [aps_pkg::AGE_W-1:0]         age_mem  [aps_pkg::TASK_SLOTS];
  logic [aps_pkg::SLOT_W-1:0]        list_mem [aps_pkg::TASK_SLOTS];
  logic [aps_pkg::TASK_SLOTS-1:0]    flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < aps_pkg::TASK_SLOTS; i++) begin
        prio_mem[i] <= '0;
        age_mem[i]  <= '0;
      end
      flags <= '0;
      count <= '0;
    end else begin
      if (wr.prio_we) begin
        prio_mem[wr.task_waddr] <= wr.prio_wdata;
      end
      if (wr.age_we) begin
        age_mem[wr.task_waddr] <= wr.age_wdata;
      end
      if (wr.flag_we) begin
        flags[wr.flag_waddr] <= wr.flag_wdata;
      end
      if (wr.count_we) begin
        count <= wr.count_wdata;
      end
    end
  end

  // The ready list is only used at positions below the count, so it needs no reset.
  always_ff @(posedge clk) begin
    if (wr.list_we) begin
      list_mem[wr.list_waddr] <= wr.list_wdata;
    end
  end

  assign prio_rd = prio_mem[task_raddr];
  assign age_rd  = age_mem[task_raddr];
  assign list_rd = list_mem[list_raddr];
  assign flag_rd = flags[flag_raddr];

  `APS_ASSERT_ALWAYS(a_count_bound, 32'(count) <= aps_pkg::TASK_SLOTS, "ready count beyond slots")

endmodule

// ===== rtl/aging_priority_scheduler_top.sv =====
// Top level of the aging priority scheduler: request sequencer and its datapath.
//
//   Channel   Signals                               Handshake
//   request   opcode, task_slot, new_priority       start high while busy low
//   result    status, chosen_slot, chosen_priority  done high for one cycle
//
// Set, append and every request refused at its first check finish in the execute state;
// remove then searches for and compacts out its list entry, and schedule scans, ages,
// restores the chosen task and then compacts the ready list.
// The single ready-list read port and the shared arithmetic unit handle one
// list entry per cycle in the scan, aging and list-compaction passes.
// Reset (rst, synchronous) clears priorities, aging counts, flags and count.
// The receiver cannot stall: the result is shown for one cycle only, and a new
// request may be accepted meanwhile.
`include "aging_priority_scheduler_top_macros.svh"

module aging_priority_scheduler_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         opcode,
  input  logic [3:0]         task_slot,
  input  logic signed [5:0]  new_priority,
  output logic               done,
  output logic [1:0]         status,
  output logic [3:0]         chosen_slot,
  output logic signed [15:0] chosen_priority
);

  aps_pkg::state_t                    state, state_next;
  logic [1:0]                         op_r;
  logic [3:0]                         slot_r;
  logic signed [5:0]                  prio_r;
  logic [aps_pkg::CNT_W-1:0]          idx, idx_next;
  logic [aps_pkg::SLOT_W-1:0]         best_pos, best_pos_next;
  logic [aps_pkg::SLOT_W-1:0]         best_slot, best_slot_next;
  logic signed [aps_pkg::PRIO_W-1:0]  best_prio, best_prio_next;
  logic                               done_next;
  logic [1:0]                         status_next;
  logic [3:0]                         chosen_slot_next;
  logic signed [15:0]                 chosen_priority_next;

  aps_pkg::store_wr_t                 wr;
  logic [aps_pkg::SLOT_W-1:0]         task_raddr;
  logic [aps_pkg::SLOT_W-1:0]         list_raddr;
  logic [aps_pkg::SLOT_W-1:0]         slot_idx;
  logic signed [aps_pkg::PRIO_W-1:0]  prio_rd;
  logic [aps_pkg::AGE_W-1:0]          age_rd;
  logic [aps_pkg::SLOT_W-1:0]         list_rd;
  logic                               flag_rd;
  logic [aps_pkg::CNT_W-1:0]          count;

  aps_pkg::alu_op_t                   alu_op;
  logic                               alu_lt;
  logic signed [aps_pkg::PRIO_W-1:0]  alu_prio;
  logic [aps_pkg::AGE_W-1:0]          alu_age;

  logic                               slot_ok;
  logic                               last;
  logic [aps_pkg::CNT_W-1:0]          idx_inc;

  assign busy     = (state != aps_pkg::S_IDLE);
  assign slot_idx = aps_pkg::SLOT_W'(slot_r);
  assign slot_ok  = (32'(slot_r) < aps_pkg::TASK_SLOTS);
  assign idx_inc  = idx + aps_pkg::CNT_W'(1);
  assign last     = (idx_inc >= count);

  aps_store u_store (
    .clk        (clk),
    .rst        (rst),
    .wr         (wr),
    .task_raddr (task_raddr),
    .list_raddr (list_raddr),
    .flag_raddr (slot_idx),
    .prio_rd    (prio_rd),
    .age_rd     (age_rd),
    .list_rd    (list_rd),
    .flag_rd    (flag_rd),
    .count      (count)
  );

  aps_alu u_alu (
    .op       (alu_op),
    .a        (prio_rd),
    .b        (best_prio),
    .age      (age_rd),
    .lt       (alu_lt),
    .prio_res (alu_prio),
    .age_res  (alu_age)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= aps_pkg::S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_r   <= opcode;
      slot_r <= task_slot;
      prio_r <= new_priority;
    end
    idx             <= idx_next;
    best_pos        <= best_pos_next;
    best_slot       <= best_slot_next;
    best_prio       <= best_prio_next;
    status          <= status_next;
    chosen_slot     <= chosen_slot_next;
    chosen_priority <= chosen_priority_next;
  end

  always_comb begin
    state_next           = state;
    idx_next             = idx;
    best_pos_next        = best_pos;
    best_slot_next       = best_slot;
    best_prio_next       = best_prio;
    done_next            = 1'b0;
    status_next          = status;
    chosen_slot_next     = chosen_slot;
    chosen_priority_next = chosen_priority;
    wr                   = '0;
    list_raddr           = aps_pkg::SLOT_W'(idx);
    task_raddr           = list_rd;
    alu_op               = aps_pkg::ALU_CMP;

    case (state)
      aps_pkg::S_IDLE: begin
        if (start) begin
          state_next = aps_pkg::S_EXEC;
        end
      end

      aps_pkg::S_EXEC: begin
        status_next          = aps_pkg::STAT_OK;
        chosen_slot_next     = '0;
        chosen_priority_next = '0;
        idx_next             = '0;
        if (op_r == aps_pkg::OP_SCHED) begin
          if (count == '0) begin
            status_next = aps_pkg::STAT_EMPTY;
            done_next   = 1'b1;
            state_next  = aps_pkg::S_IDLE;
          end else begin
            state_next = aps_pkg::S_SELECT;
          end
        end else if (!slot_ok) begin
          status_next = aps_pkg::STAT_LISTED;
          done_next   = 1'b1;
          state_next  = aps_pkg::S_IDLE;
        end else if (op_r == aps_pkg::OP_SET) begin
          if (prio_r > aps_pkg::PRIO_ACCEPT_LOW && prio_r < aps_pkg::PRIO_ACCEPT_HIGH) begin
            wr.prio_we    = 1'b1;
            wr.task_waddr = slot_idx;
            wr.prio_wdata = aps_pkg::PRIO_W'(prio_r);
          end else begin
            status_next = aps_pkg::STAT_REJECT;
          end
          done_next  = 1'b1;
          state_next = aps_pkg::S_IDLE;
        end else if (op_r == aps_pkg::OP_APPEND) begin
          if (flag_rd || 32'(count) >= aps_pkg::TASK_SLOTS) begin
            status_next = aps_pkg::STAT_LISTED;
          end else begin
            wr.list_we     = 1'b1;
            wr.list_waddr  = aps_pkg::SLOT_W'(count);
            wr.list_wdata  = slot_idx;
            wr.flag_we     = 1'b1;
            wr.flag_waddr  = slot_idx;
            wr.flag_wdata  = 1'b1;
            wr.count_we    = 1'b1;
            wr.count_wdata = count + aps_pkg::CNT_W'(1);
          end
          done_next  = 1'b1;
          state_next = aps_pkg::S_IDLE;
        end else begin
          if (!flag_rd) begin
            status_next = aps_pkg::STAT_LISTED;
            done_next   = 1'b1;
            state_next  = aps_pkg::S_IDLE;
          end else begin
            state_next = aps_pkg::S_FIND;
          end
        end
      end

      aps_pkg::S_FIND: begin
        // The listed flag guarantees that the slot is somewhere in the list.
        if (list_rd == slot_idx) begin
          wr.flag_we    = 1'b1;
          wr.flag_waddr = slot_idx;
          wr.flag_wdata = 1'b0;
          state_next    = aps_pkg::S_SHIFT;
        end else begin
          idx_next = idx_inc;
        end
      end

      aps_pkg::S_SHIFT: begin
        list_raddr = aps_pkg::SLOT_W'(idx_inc);
        if (!last) begin
          wr.list_we    = 1'b1;
          wr.list_waddr = aps_pkg::SLOT_W'(idx);
          wr.list_wdata = list_rd;
          idx_next      = idx_inc;
        end else begin
          wr.count_we    = 1'b1;
          wr.count_wdata = count - aps_pkg::CNT_W'(1);
          if (op_r == aps_pkg::OP_SCHED) begin
            chosen_slot_next     = 4'(best_slot);
            chosen_priority_next = best_prio;
          end
          done_next  = 1'b1;
          state_next = aps_pkg::S_IDLE;
        end
      end

      aps_pkg::S_SELECT: begin
        alu_op = aps_pkg::ALU_CMP;
        // Strictly smaller wins, so a tie keeps the earlier list entry.
        if (idx == '0 || alu_lt) begin
          best_pos_next  = aps_pkg::SLOT_W'(idx);
          best_slot_next = list_rd;
          best_prio_next = prio_rd;
        end
        if (last) begin
          idx_next   = '0;
          state_next = aps_pkg::S_AGE;
        end else begin
          idx_next = idx_inc;
        end
      end

      aps_pkg::S_AGE: begin
        alu_op = aps_pkg::ALU_AGE;
        if (aps_pkg::SLOT_W'(idx) != best_pos) begin
          wr.prio_we    = 1'b1;
          wr.age_we     = 1'b1;
          wr.task_waddr = list_rd;
          wr.prio_wdata = alu_prio;
          wr.age_wdata  = alu_age;
        end
        if (last) begin
          state_next = aps_pkg::S_RESTORE;
        end else begin
          idx_next = idx_inc;
        end
      end

      aps_pkg::S_RESTORE: begin
        alu_op         = aps_pkg::ALU_RESTORE;
        task_raddr     = best_slot;
        wr.prio_we     = 1'b1;
        wr.age_we      = 1'b1;
        wr.task_waddr  = best_slot;
        wr.prio_wdata  = alu_prio;
        wr.age_wdata   = alu_age;
        wr.flag_we     = 1'b1;
        wr.flag_waddr  = best_slot;
        wr.flag_wdata  = 1'b0;
        best_prio_next = alu_prio;
        idx_next       = aps_pkg::CNT_W'(best_pos);
        state_next     = aps_pkg::S_SHIFT;
      end

      default: begin
        state_next = aps_pkg::S_IDLE;
      end
    endcase
  end

  `APS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
  `APS_ASSERT_IMPLY(a_done_after_work, done, $past(busy), "result without a request in progress")
  `APS_ASSERT_IMPLY(a_empty_zero, done && status == aps_pkg::STAT_EMPTY, chosen_slot == '0 && chosen_priority == '0, "empty schedule reported a task")
  `APS_ASSERT_IMPLY(a_scan_nonempty, state == aps_pkg::S_SELECT || state == aps_pkg::S_AGE, count != '0, "scan over an empty ready list")

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the aging priority scheduler: directed rows, random requests, aging run.
module testbench;

  typedef struct packed {
    logic [1:0]                        status;
    logic [aps_pkg::SLOT_W-1:0]        slot;
    logic signed [aps_pkg::PRIO_W-1:0] prio;
  } sched_result_t;

  typedef struct {
    logic [1:0]                 op;
    logic [aps_pkg::SLOT_W-1:0] slot;
    logic signed [5:0]          prio;
    bit                         typed;
    sched_result_t              res;
  } request_row_t;

  localparam int CYCLE_LIMIT     = 2_000_000;
  localparam int RANDOM_REQUESTS = 600;
  localparam int AGING_ROUNDS    = 12;
  localparam int DRAIN_CYCLES    = 64;
  localparam int MAX_REPORTS     = 10;

  logic                              clk;
  logic                              rst;
  logic                              start;
  logic                              busy;
  logic [1:0]                        opcode;
  logic [aps_pkg::SLOT_W-1:0]        task_slot;
  logic signed [5:0]                 new_priority;
  logic                              done;
  logic [1:0]                        status;
  logic [aps_pkg::SLOT_W-1:0]        chosen_slot;
  logic signed [aps_pkg::PRIO_W-1:0] chosen_priority;

  // Predicted scheduler state.
  logic signed [aps_pkg::PRIO_W-1:0] prio_now   [aps_pkg::TASK_SLOTS];
  logic [aps_pkg::AGE_W-1:0]         age_now    [aps_pkg::TASK_SLOTS];
  logic [aps_pkg::SLOT_W-1:0]        ready_list [aps_pkg::TASK_SLOTS];
  bit                                on_list    [aps_pkg::TASK_SLOTS];
  int                                ready_len;

  sched_result_t pending_results [$];
  request_row_t  directed_rows [$];
  sched_result_t oldest;
  int            mismatches;
  int            cycles;
  bit            burst;

  aging_priority_scheduler_top u_dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .opcode          (opcode),
    .task_slot       (task_slot),
    .new_priority    (new_priority),
    .done            (done),
    .status          (status),
    .chosen_slot     (chosen_slot),
    .chosen_priority (chosen_priority)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic void drop_entry(int pos);
    for (int i = pos; i + 1 < ready_len; i++) begin
      ready_list[i] = ready_list[i + 1];
    end
    ready_len--;
  endfunction

  // Applies one accepted request to the predicted state and returns its result.
  function automatic sched_result_t apply_request(logic [1:0] op,
                                                  logic [aps_pkg::SLOT_W-1:0] slot,
                                                  logic signed [5:0] np);
    sched_result_t              r;
    int                         best;
    int                         sum;
    logic [aps_pkg::SLOT_W-1:0] t;
    r = '0;
    r.status = aps_pkg::STAT_OK;
    case (op)
      aps_pkg::OP_SCHED: begin
        if (ready_len == 0) begin
          r.status = aps_pkg::STAT_EMPTY;
        end else begin
          best = 0;
          for (int i = 1; i < ready_len; i++) begin
            if (prio_now[ready_list[i]] < prio_now[ready_list[best]]) best = i;
          end
          for (int i = 0; i < ready_len; i++) begin
            t = ready_list[i];
            if (i != best) begin
              if (age_now[t] != {aps_pkg::AGE_W{1'b1}}) age_now[t]++;
              if (prio_now[t] != aps_pkg::PRIO_MIN) prio_now[t]--;
            end
          end
          t = ready_list[best];
          sum = int'(prio_now[t]) + int'(age_now[t]);
          if (sum > aps_pkg::PRIO_MAX) sum = aps_pkg::PRIO_MAX;
          prio_now[t] = sum[aps_pkg::PRIO_W-1:0];
          age_now[t] = '0;
          on_list[t] = 1'b0;
          drop_entry(best);
          r.slot = t;
          r.prio = prio_now[t];
        end
      end
      aps_pkg::OP_SET: begin
        if (np > aps_pkg::PRIO_ACCEPT_LOW && np < aps_pkg::PRIO_ACCEPT_HIGH)
          prio_now[slot] = aps_pkg::PRIO_W'(np);
        else r.status = aps_pkg::STAT_REJECT;
      end
      aps_pkg::OP_APPEND: begin
        if (on_list[slot] || ready_len >= aps_pkg::TASK_SLOTS) begin
          r.status = aps_pkg::STAT_LISTED;
        end else begin
          ready_list[ready_len] = slot;
          ready_len++;
          on_list[slot] = 1'b1;
        end
      end
      default: begin
        if (!on_list[slot]) begin
          r.status = aps_pkg::STAT_LISTED;
        end else begin
          for (int i = 0; i < ready_len; i++) begin
            if (ready_list[i] == slot) begin
              drop_entry(i);
              break;
            end
          end
          on_list[slot] = 1'b0;
        end
      end
    endcase
    return r;
  endfunction

  function automatic int draw_gap();
    return burst ? 0 : $urandom_range(0, 10);
  endfunction

  // Picks a slot that is (or is not) on the ready list, falling back when none is.
  function automatic logic [aps_pkg::SLOT_W-1:0] pick_slot(bit want_listed,
                                                           logic [aps_pkg::SLOT_W-1:0] fallback);
    int cand [$];
    for (int i = 0; i < aps_pkg::TASK_SLOTS; i++) begin
      if (on_list[i] == want_listed) cand.push_back(i);
    end
    if (cand.size() == 0) return fallback;
    return aps_pkg::SLOT_W'(cand[$urandom_range(0, cand.size() - 1)]);
  endfunction

  task automatic add_row(logic [1:0] op, int slot, int prio, bit typed,
                         logic [1:0] st, int cs, int cp);
    request_row_t row;
    row.op = op;
    row.slot = aps_pkg::SLOT_W'(slot);
    row.prio = 6'(prio);
    row.typed = typed;
    row.res.status = st;
    row.res.slot = aps_pkg::SLOT_W'(cs);
    row.res.prio = aps_pkg::PRIO_W'(cp);
    directed_rows.push_back(row);
  endtask

  // Called at a falling edge; returns at the falling edge where the next request may be driven.
  task automatic send_request(logic [1:0] op, logic [aps_pkg::SLOT_W-1:0] slot,
                              logic signed [5:0] np, int gap, bit typed,
                              sched_result_t typed_res);
    sched_result_t r;
    opcode <= op;
    task_slot <= slot;
    new_priority <= np;
    start <= 1'b1;
    // Busy only moves on a rising edge, so a low value here means the request goes in next edge.
    while (busy) @(negedge clk);
    @(negedge clk);
    r = apply_request(op, slot, np);
    pending_results.push_back(typed ? typed_res : r);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("cycle %0d: result with none expected: status %0d slot %0d priority %0d",
                   cycles, status, chosen_slot, chosen_priority);
      end else begin
        oldest = pending_results.pop_front();
        if (status !== oldest.status || chosen_slot !== oldest.slot ||
            chosen_priority !== oldest.prio) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("cycle %0d: expected status %0d slot %0d priority %0d, got %0d %0d %0d",
                     cycles, oldest.status, oldest.slot, oldest.prio,
                     status, chosen_slot, chosen_priority);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int                         roll;
    int                         mix;
    int                         p;
    int                         waited;
    logic [1:0]                 op;
    logic [aps_pkg::SLOT_W-1:0] slot;
    logic signed [5:0]          prio;
    sched_result_t              none;

    rst = 1'b1;
    start = 1'b0;
    opcode = aps_pkg::OP_SET;
    task_slot = '0;
    new_priority = '0;
    mismatches = 0;
    cycles = 0;
    burst = 1'b0;
    none = '0;
    ready_len = 0;
    for (int i = 0; i < aps_pkg::TASK_SLOTS; i++) begin
      prio_now[i] = '0;
      age_now[i] = '0;
      ready_list[i] = '0;
      on_list[i] = 1'b0;
    end

    // Directed rows: rejects at both ends, listing errors, tie on priority, empty list.
    add_row(aps_pkg::OP_SCHED,   0,   0, 1, aps_pkg::STAT_EMPTY,   0,   0);
    add_row(aps_pkg::OP_SET,     0,  20, 1, aps_pkg::STAT_REJECT,  0,   0);
    add_row(aps_pkg::OP_SET,     1, -20, 1, aps_pkg::STAT_REJECT,  0,   0);
    add_row(aps_pkg::OP_SET,     2, -32, 1, aps_pkg::STAT_REJECT,  0,   0);
    add_row(aps_pkg::OP_SET,     3,  31, 1, aps_pkg::STAT_REJECT,  0,   0);
    add_row(aps_pkg::OP_SET,     0,  19, 1, aps_pkg::STAT_OK,      0,   0);
    add_row(aps_pkg::OP_SET,    15, -19, 1, aps_pkg::STAT_OK,      0,   0);
    add_row(aps_pkg::OP_REMOVE,  4,   0, 1, aps_pkg::STAT_LISTED,  0,   0);
    add_row(aps_pkg::OP_APPEND,  0,   0, 1, aps_pkg::STAT_OK,      0,   0);
    add_row(aps_pkg::OP_APPEND,  0,   0, 1, aps_pkg::STAT_LISTED,  0,   0);
    add_row(aps_pkg::OP_APPEND, 15,   0, 1, aps_pkg::STAT_OK,      0,   0);
    add_row(aps_pkg::OP_APPEND,  7,   0, 1, aps_pkg::STAT_OK,      0,   0);
    add_row(aps_pkg::OP_SET,     7, -19, 1, aps_pkg::STAT_OK,      0,   0);
    add_row(aps_pkg::OP_SCHED,   0,   0, 1, aps_pkg::STAT_OK,     15, -19);
    add_row(aps_pkg::OP_SCHED,  15, -32, 0, aps_pkg::STAT_OK,      0,   0);
    add_row(aps_pkg::OP_APPEND, 15,   0, 0, aps_pkg::STAT_OK,      0,   0);
    add_row(aps_pkg::OP_REMOVE,  0,   0, 1, aps_pkg::STAT_OK,      0,   0);
    add_row(aps_pkg::OP_REMOVE,  0,   0, 1, aps_pkg::STAT_LISTED,  0,   0);
    add_row(aps_pkg::OP_SET,     9,  -1, 1, aps_pkg::STAT_OK,      0,   0);
    add_row(aps_pkg::OP_APPEND,  9,   0, 0, aps_pkg::STAT_OK,      0,   0);
    add_row(aps_pkg::OP_SCHED,   0,  31, 0, aps_pkg::STAT_OK,      0,   0);
    add_row(aps_pkg::OP_SCHED,   0,   0, 0, aps_pkg::STAT_OK,      0,   0);
    add_row(aps_pkg::OP_SCHED,   0,   0, 1, aps_pkg::STAT_EMPTY,   0,   0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].op, directed_rows[i].slot, directed_rows[i].prio,
                   draw_gap(), directed_rows[i].typed, directed_rows[i].res);
    end

    // Random requests, mostly well-formed, with the mix drifting between filling and draining.
    mix = 0;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 40 == 0) begin
        mix = $urandom_range(0, 2);
        burst = ($urandom_range(0, 3) == 0);
      end
      roll = $urandom_range(0, 99);
      case (mix)
        0: op = (roll < 20) ? aps_pkg::OP_SET : (roll < 50) ? aps_pkg::OP_APPEND :
                (roll < 65) ? aps_pkg::OP_REMOVE : aps_pkg::OP_SCHED;
        1: op = (roll < 15) ? aps_pkg::OP_SET : (roll < 70) ? aps_pkg::OP_APPEND :
                (roll < 78) ? aps_pkg::OP_REMOVE : aps_pkg::OP_SCHED;
        default:
           op = (roll < 15) ? aps_pkg::OP_SET : (roll < 35) ? aps_pkg::OP_APPEND :
                (roll < 50) ? aps_pkg::OP_REMOVE : aps_pkg::OP_SCHED;
      endcase
      slot = aps_pkg::SLOT_W'($urandom_range(0, aps_pkg::TASK_SLOTS - 1));
      prio = 6'($urandom_range(0, 63));
      if (op == aps_pkg::OP_SET && $urandom_range(0, 4) != 0) begin
        p = $urandom_range(0, 38);
        prio = 6'(p - 19);
      end
      if (op == aps_pkg::OP_APPEND && $urandom_range(0, 6) != 0) slot = pick_slot(1'b0, slot);
      if (op == aps_pkg::OP_REMOVE && $urandom_range(0, 6) != 0) slot = pick_slot(1'b1, slot);
      send_request(op, slot, prio, draw_gap(), 1'b0, none);
    end

    // Aging run: task 2 stays listed and ages while task 1 keeps being chosen, and its
    // aging count is added back when it is finally picked itself.
    burst = 1'b1;
    for (int i = 0; i < aps_pkg::TASK_SLOTS; i++) begin
      if (on_list[i])
        send_request(aps_pkg::OP_REMOVE, aps_pkg::SLOT_W'(i), 6'sd0, 0, 1'b0, none);
    end
    send_request(aps_pkg::OP_SET, 4'd1, -6'sd19, 0, 1'b0, none);
    send_request(aps_pkg::OP_APPEND, 4'd2, 6'sd0, 0, 1'b0, none);
    for (int i = 0; i < AGING_ROUNDS; i++) begin
      // Task 2 loses a point per round; lift it before it ties with task 1 and wins.
      if (i % 30 == 0) send_request(aps_pkg::OP_SET, 4'd2, 6'sd19, 0, 1'b0, none);
      send_request(aps_pkg::OP_APPEND, 4'd1, 6'sd0, 0, 1'b0, none);
      send_request(aps_pkg::OP_SCHED, 4'd0, 6'sd0, 0, 1'b0, none);
    end
    send_request(aps_pkg::OP_SCHED, 4'd0, 6'sd0, 0, 1'b0, none);
    send_request(aps_pkg::OP_SCHED, 4'd0, 6'sd0, 0, 1'b0, none);
    start <= 1'b0;

    waited = 0;
    while (pending_results.size() != 0 && waited < 10_000) begin
      @(negedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (pending_results.size() != 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0d expected results never arrived", pending_results.size());
    end

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/aps_pkg.sv
rtl/aps_alu.sv
rtl/aps_store.sv
rtl/aging_priority_scheduler_top.sv
verif/testbench.sv
